// File: src/hyph_pkg.sv
// Shared types, constants and character classification for the syllable hyphenator.
package hyph_pkg;

   localparam int unsigned CHAR_W = 8;

   // Configuration register indexes.
   localparam logic CSR_HYPHEN = 1'b0;
   localparam logic CSR_SPACE  = 1'b1;

   localparam logic [CHAR_W-1:0] HYPHEN_RESET = 8'd45;
   localparam logic [CHAR_W-1:0] SPACE_RESET  = 8'd32;

   typedef enum logic [1:0] {
      CLS_GAP,
      CLS_VOWEL,
      CLS_CONS
   } cls_type;

   // One accepted item's worth of output: up to four text bytes, each
   // optionally followed by a hyphen.
   typedef struct packed {
      logic [3:0][CHAR_W-1:0] chars;
      logic [3:0]             hyph;
      logic [2:0]             cnt;
      logic                   eot;
   } load_type;

   function automatic logic is_vowel(input logic [CHAR_W-1:0] b);
      logic v;
      case (b)
         8'h61, 8'h65, 8'h69, 8'h6F, 8'h75,
         8'h41, 8'h45, 8'h49, 8'h4F, 8'h55,
         8'hFD, 8'hDD, 8'hF6, 8'hD6, 8'hFC, 8'hDC: v = 1'b1;
         default: v = 1'b0;
      endcase
      return v;
   endfunction

   function automatic cls_type char_class(input logic [CHAR_W-1:0] b,
                                          input logic [CHAR_W-1:0] space);
      cls_type c;
      if (b == space) begin
         c = CLS_GAP;
      end else if (is_vowel(b)) begin
         c = CLS_VOWEL;
      end else begin
         c = CLS_CONS;
      end
      return c;
   endfunction

   // Boundary offsets caused by a vowel at c0: bit k means a hyphen after c0+k.
   function automatic logic [2:0] judge(input cls_type c0, input cls_type c1,
                                        input cls_type c2, input cls_type c3);
      logic [2:0] r;
      r = 3'b000;
      if (c0 == CLS_VOWEL) begin
         if (c1 == CLS_VOWEL) begin
            r = 3'b001;
         end else if (c1 == CLS_CONS) begin
            if (c2 == CLS_VOWEL) begin
               r = 3'b001;
            end else if (c2 == CLS_CONS) begin
               if (c3 == CLS_VOWEL) begin
                  r = 3'b010;
               end else if (c3 == CLS_CONS) begin
                  r = 3'b100;
               end
            end
         end
      end
      return r;
   endfunction

endpackage

// File: src/hyph_window.sv
// Look-ahead window: holds pending bytes and marks, decides boundaries per item.
module hyph_window (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [hyph_pkg::CHAR_W-1:0]    in_char,
   input  logic                           end_of_text,
   input  logic [hyph_pkg::CHAR_W-1:0]    space_char,
   output hyph_pkg::load_type             load
);
   import hyph_pkg::*;

   logic [2:0][CHAR_W-1:0] win_ff, win_in;
   logic [1:0]             cnt_ff, cnt_in;
   logic [2:0]             marks_ff, marks_in;

   logic [3:0][CHAR_W-1:0] w;
   cls_type                c [7];
   logic [2:0]             m;
   logic [2:0]             j0, j1, j2, j3;
   logic [3:0]             mk;

   always_comb begin
      for (int p = 0; p < 3; p++) begin
         w[p] = (3'(p) < {1'b0, cnt_ff}) ? win_ff[p] : in_char;
      end
      w[3] = in_char;
      m = {1'b0, cnt_ff} + 3'd1;
      for (int p = 0; p < 4; p++) begin
         c[p] = (3'(p) < m) ? char_class(w[p], space_char) : CLS_GAP;
      end
      for (int p = 4; p < 7; p++) begin
         c[p] = CLS_GAP;
      end
   end

   assign j0 = judge(c[0], c[1], c[2], c[3]);
   assign j1 = judge(c[1], c[2], c[3], c[4]);
   assign j2 = judge(c[2], c[3], c[4], c[5]);
   assign j3 = judge(c[3], c[4], c[5], c[6]);

   always_comb begin
      mk = {1'b0, marks_ff} | {1'b0, j0};
      if (end_of_text) begin
         mk = mk | {j1, 1'b0} | {j2[1:0], 2'b00} | {j3[0], 3'b000};
         // No hyphen after the final byte of a text.
         mk[2'(m - 3'd1)] = 1'b0;
      end
   end

   always_comb begin
      load.chars = w;
      load.hyph  = mk;
      load.cnt   = 3'd0;
      load.eot   = end_of_text;
      win_in     = win_ff;
      cnt_in     = cnt_ff;
      marks_in   = marks_ff;
      if (end_of_text) begin
         load.cnt = m;
         cnt_in   = 2'd0;
         marks_in = 3'd0;
      end else if (m == 3'd4) begin
         load.cnt = 3'd1;
         win_in   = {w[3], w[2], w[1]};
         cnt_in   = 2'd3;
         marks_in = mk[3:1];
      end else begin
         win_in[cnt_ff] = in_char;
         cnt_in         = m[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= 2'd0;
         marks_ff <= 3'd0;
      end else if (accept) begin
         cnt_ff   <= cnt_in;
         marks_ff <= marks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

endmodule

// File: src/hyph_outbuf.sv
// Result buffer: steps through one item's bytes and hyphens, one per cycle while rsp_tready is high.
module hyph_outbuf (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load_en,
   input  hyph_pkg::load_type             load,
   input  logic [hyph_pkg::CHAR_W-1:0]    hyphen_char,
   output logic                           can_load,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [hyph_pkg::CHAR_W-1:0]    rsp_tdata,
   output logic                           rsp_tlast
);
   import hyph_pkg::*;

   logic [3:0][CHAR_W-1:0] chars_ff;
   logic [3:0]             hyph_ff;
   logic [2:0]             cnt_ff;
   logic                   eot_ff;
   logic                   busy_ff, busy_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   phase_ff, phase_in;

   logic at_last_byte, to_hyphen, final_beat, take;

   assign at_last_byte = ({1'b0, idx_ff} == (cnt_ff - 3'd1));
   assign to_hyphen    = !phase_ff && hyph_ff[idx_ff];
   assign take         = busy_ff && rsp_tready;
   assign final_beat   = take && at_last_byte && !to_hyphen;
   assign can_load     = !busy_ff || final_beat;

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = phase_ff ? hyphen_char : chars_ff[idx_ff];
   assign rsp_tlast  = eot_ff && at_last_byte && !to_hyphen;

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      if (take) begin
         if (to_hyphen) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            idx_in   = idx_ff + 2'd1;
            if (at_last_byte) begin
               busy_in = 1'b0;
            end
         end
      end
      if (load_en) begin
         busy_in  = (load.cnt != 3'd0);
         idx_in   = 2'd0;
         phase_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= 2'd0;
         phase_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         chars_ff <= load.chars;
         hyph_ff  <= load.hyph;
         cnt_ff   <= load.cnt;
         eot_ff   <= load.eot;
      end
   end

endmodule

// File: src/turkish_syllable_hyphenator.sv
// Top level: Turkish syllable hyphenator over a byte stream.
// The first result of an item, if it has any, is on rsp in the cycle after it is accepted.
// One result per cycle while rsp_tready is high; a byte with a hyphen after it gives two results,
// and an end-of-text item flushes up to four bytes and three hyphens.
// The next item is accepted in the cycle the previous item's last result is taken.
// Reset clears the window, the marks and the result buffer; hyphen is 45, space 32.
module turkish_syllable_hyphenator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] in_char
   input  logic                           req_tlast,   // end_of_text
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [7:0] out_char
   output logic                           rsp_tlast,   // last_out
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [7:0]                     csr_wdata
);
   import hyph_pkg::*;

   logic [CHAR_W-1:0] hyphen_ff, space_ff;
   logic              accept;
   load_type          load;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hyphen_ff <= HYPHEN_RESET;
         space_ff  <= SPACE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HYPHEN: hyphen_ff <= csr_wdata;
            CSR_SPACE:  space_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   hyph_window u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_char     (req_tdata),
      .end_of_text (req_tlast),
      .space_char  (space_ff),
      .load        (load)
   );

   hyph_outbuf u_outbuf (
      .clock       (clock),
      .reset       (reset),
      .load_en     (accept),
      .load        (load),
      .hyphen_char (hyphen_ff),
      .can_load    (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// File: verif/hyph_checker.sv
// Checker for the syllable hyphenator: predicts the output byte stream and compares it.
module hyph_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   output int         mismatch_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import hyph_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_byte_type;

   text_byte_type expected_bytes[$];
   logic [7:0]  pend_chars [4];
   int unsigned pend_count;
   logic [3:0]  hyph_after;
   logic [7:0]  hyphen_code;
   logic [7:0]  space_code;
   int          errors = 0;

   function automatic logic turkish_vowel(input logic [7:0] b);
      return b inside {"a", "e", "i", "o", "u", "A", "E", "I", "O", "U",
                       8'hFD, 8'hDD, 8'hF6, 8'hD6, 8'hFC, 8'hDC};
   endfunction

   // Positions past the known bytes read as a word gap, like the space byte.
   function automatic cls_type kind_at(input int unsigned idx, input int unsigned n);
      if (idx >= n || pend_chars[idx] == space_code) begin
         return CLS_GAP;
      end
      return turkish_vowel(pend_chars[idx]) ? CLS_VOWEL : CLS_CONS;
   endfunction

   function automatic void mark_boundaries(input int unsigned n);
      cls_type c1, c2, c3;
      if (kind_at(0, n) != CLS_VOWEL) begin
         return;
      end
      c1 = kind_at(1, n);
      c2 = kind_at(2, n);
      c3 = kind_at(3, n);
      if (c1 == CLS_VOWEL) begin
         hyph_after[0] = 1'b1;
      end else if (c1 == CLS_CONS) begin
         if (c2 == CLS_VOWEL) begin
            hyph_after[0] = 1'b1;
         end else if (c2 == CLS_CONS) begin
            if (c3 == CLS_VOWEL) begin
               hyph_after[1] = 1'b1;
            end else if (c3 == CLS_CONS) begin
               hyph_after[2] = 1'b1;
            end
         end
      end
   endfunction

   function automatic void emit_oldest();
      expected_bytes.push_back({pend_chars[0], 1'b0});
      if (hyph_after[0]) begin
         expected_bytes.push_back({hyphen_code, 1'b0});
      end
      for (int k = 0; k < 3; k++) begin
         pend_chars[k] = pend_chars[k + 1];
      end
      pend_chars[3] = 8'h00;
      hyph_after = hyph_after >> 1;
   endfunction

   function automatic void clear_window();
      for (int k = 0; k < 4; k++) begin
         pend_chars[k] = 8'h00;
      end
      pend_count = 0;
      hyph_after = 4'b0000;
   endfunction

   function automatic void predict_item(input logic [7:0] ch, input logic eot);
      text_byte_type tail;
      pend_chars[pend_count] = ch;
      pend_count++;
      if (!eot) begin
         if (pend_count == 4) begin
            mark_boundaries(4);
            emit_oldest();
            pend_count = 3;
         end
      end else begin
         // The end of text flushes the window; no hyphen goes after the final byte.
         while (pend_count > 0) begin
            mark_boundaries(pend_count);
            if (pend_count == 1) begin
               hyph_after[0] = 1'b0;
            end
            emit_oldest();
            pend_count--;
         end
         tail = expected_bytes.pop_back();
         tail.last = 1'b1;
         expected_bytes.push_back(tail);
         clear_window();
      end
   endfunction

   always @(posedge clock) begin
      text_byte_type want;
      if (reset) begin
         clear_window();
         hyphen_code = HYPHEN_RESET;
         space_code  = SPACE_RESET;
         expected_bytes.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_HYPHEN) begin
               hyphen_code = csr_wdata;
            end else begin
               space_code = csr_wdata;
            end
         end
         // A result never belongs to the item accepted at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t: unexpected output byte %h last %b",
                           $realtime, rsp_tdata, rsp_tlast);
               end
            end else begin
               want = expected_bytes.pop_front();
               if (want.ch !== rsp_tdata || want.last !== rsp_tlast) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: out_char expected %h got %h, last_out expected %b got %b",
                              $realtime, want.ch, rsp_tdata, want.last, rsp_tlast);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_item(req_tdata, req_tlast);
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_bytes.size();
   end

endmodule

// File: verif/testbench.sv
// Top of the hyphenator testbench: clock, reset, text stimulus, receiver stalls and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hyph_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_wr_en;
   logic       csr_index;
   logic [7:0] csr_wdata;
   int         mismatch_count;
   int         pending_count;

   logic       long_hold;
   bit         gaps_on;
   int         burst_left;
   int         cycle_count;
   logic [7:0] cur_space;
   string      consonants = "bcdfghjklmnprstvyzBCDGKLMNRSTZ";

   turkish_syllable_hyphenator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   hyph_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: picks a new stall behavior at random after each random stretch, and once holds
   // off for a long stretch so that the block backs up into its input.
   initial begin
      rx_mode_type mode;
      int       stretch;
      bit       hold_done;
      mode      = RX_FREE;
      stretch   = 0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         if (stretch == 0) begin
            mode    = rx_mode_type'($urandom_range(0, 3));
            stretch = $urandom_range(20, 120);
         end
         stretch--;
         case (mode)
            RX_FREE:     rsp_tready <= 1'b1;
            RX_RANDOM:   rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rsp_tready <= (stretch % 4 != 0);
            default:     rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   function automatic logic [7:0] pick_vowel();
      case ($urandom_range(0, 15))
         0:  return "a";
         1:  return "e";
         2:  return "i";
         3:  return "o";
         4:  return "u";
         5:  return "A";
         6:  return "E";
         7:  return "I";
         8:  return "O";
         9:  return "U";
         10: return 8'hFD;
         11: return 8'hDD;
         12: return 8'hF6;
         13: return 8'hD6;
         14: return 8'hFC;
         default: return 8'hDC;
      endcase
   endfunction

   function automatic logic [7:0] pick_text_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return pick_vowel();
      end else if (r < 85) begin
         return consonants[$urandom_range(0, consonants.len() - 1)];
      end else if (r < 93) begin
         return cur_space;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Offers one item and waits for it to be taken, then, with gaps on, idles between bursts.
   task automatic send_byte(input logic [7:0] ch, input logic eot);
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (gaps_on) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task automatic send_word(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], i == s.len() - 1);
      end
   endtask

   task automatic send_text(input int len, input bit noise);
      logic [7:0] ch;
      for (int i = 0; i < len; i++) begin
         ch = noise ? 8'($urandom_range(0, 255)) : pick_text_byte();
         send_byte(ch, i == len - 1);
      end
   endtask

   // Stop offering items and wait until every predicted byte has come out.
   task automatic drain();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] hyphen, input logic [7:0] space);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_HYPHEN;
      csr_wdata <= hyphen;
      @(posedge clock);
      csr_index <= CSR_SPACE;
      csr_wdata <= space;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_space = space;
      @(posedge clock);
   endtask

   // Mostly word-like texts; now and then a text of arbitrary bytes.
   task automatic run_phase(input int target);
      int sent;
      int len;
      sent = 0;
      while (sent < target) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
         send_text(len, $urandom_range(0, 9) == 0);
         sent += len;
      end
      drain();
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tlast   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_HYPHEN;
      csr_wdata   = 8'h00;
      long_hold   = 1'b0;
      gaps_on     = 1'b1;
      burst_left  = 0;
      cycle_count = 0;
      cur_space   = SPACE_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Single vowel, vowel-vowel, two and three consonants, a word that ends on a
      // consonant, then the extreme and special byte codes.
      send_word("a");
      send_word("saat");
      send_word("arka");
      send_word("ertsi");
      send_word("ab");
      send_byte(8'h00, 1'b0);
      send_byte(8'hDD, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'hFC, 1'b1);
      drain();

      run_phase(24);

      set_config(8'h00, 8'hFF);
      run_phase(24);

      // Zero byte as the word gap; receiver holds off while items keep coming.
      set_config(8'hFF, 8'h00);
      gaps_on = 1'b0;
      long_hold <= 1'b1;
      run_phase(24);
      gaps_on = 1'b1;

      // The word gap is a vowel code, so that letter separates words.
      set_config(8'h2D, "a");
      run_phase(24);

      set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_phase(24);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
